// ===== rtl/etpt_pkg.sv =====
// Shared types and constants of the encoder turn and position tracker.
package etpt_pkg;

  localparam int unsigned CountWidth = 64;
  localparam int unsigned DeltaWidth = 32;
  localparam int unsigned ResWidth   = 32;
  localparam int unsigned DigitWidth = 8;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 32;

  localparam logic [CfgIndexWidth-1:0] REG_ENCODER_RESOLUTION = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_INPUT_ENABLE       = 2'd1;

  localparam logic [ResWidth-1:0] RESOLUTION_RESET   = 32'd131072;
  localparam logic                INPUT_ENABLE_RESET = 1'b1;

  localparam logic [DeltaWidth-1:0] TURNS_MAX = 32'h7FFF_FFFF;
  localparam logic [DeltaWidth-1:0] TURNS_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_NEG,
    DV_RUN
  } div_phase_t;

  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic                  done;
    logic                  negative;
    logic [CountWidth-1:0] quotient;
    logic [ResWidth-1:0]   remainder;
  } div_result_t;

endpackage

// ===== rtl/etpt_accum.sv =====
// Running pulse total with a byte-serial adder for the signed delta.
module etpt_accum (
  input  logic                              clk,
  input  logic                              rst,
  input  etpt_pkg::acc_ctrl_t               ctrl,
  input  logic [etpt_pkg::DeltaWidth-1:0]   delta,
  output logic [etpt_pkg::CountWidth-1:0]   total,
  output logic                              done
);
  import etpt_pkg::*;

  logic [DeltaWidth-1:0] dlt;
  logic                  sgn;
  logic                  carry;
  logic                  busy;
  logic [2:0]            cnt;
  logic [DigitWidth-1:0] addend;
  logic [DigitWidth:0]   sum;

  // The upper four digits of the delta are its sign extension.
  assign addend = cnt[2] ? {DigitWidth{sgn}} : dlt[DigitWidth-1:0];
  assign sum    = {1'b0, total[DigitWidth-1:0]} + {1'b0, addend}
                  + {{DigitWidth{1'b0}}, carry};

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      carry <= 1'b0;
    end else begin
      done <= busy && !ctrl.clear && !ctrl.start && (cnt == 3'd7);
      if (ctrl.clear) begin
        total <= '0;
        busy  <= 1'b0;
      end else if (ctrl.start) begin
        dlt   <= delta;
        sgn   <= delta[DeltaWidth-1];
        busy  <= 1'b1;
        cnt   <= '0;
        carry <= 1'b0;
      end else if (busy) begin
        // The total rotates right one byte per cycle, so after eight steps
        // every byte is back in its place.
        total <= {sum[DigitWidth-1:0], total[CountWidth-1:DigitWidth]};
        dlt   <= {{DigitWidth{1'b0}}, dlt[DeltaWidth-1:DigitWidth]};
        carry <= sum[DigitWidth];
        cnt   <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/etpt_divider.sv =====
// Magnitude and restoring bit-serial division of the total by the resolution.
module etpt_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [etpt_pkg::CountWidth-1:0]   dividend,
  input  logic [etpt_pkg::ResWidth-1:0]     divisor,
  output etpt_pkg::div_result_t             result
);
  import etpt_pkg::*;

  div_phase_t            phase;
  div_phase_t            phase_next;
  logic [CountWidth-1:0] dvd;
  logic [ResWidth-1:0]   rem;
  logic                  neg;
  logic                  carry;
  logic                  done;
  logic [5:0]            cnt;

  logic                  load_en;
  logic                  neg_en;
  logic                  run_en;

  logic [DigitWidth:0]   neg_sum;
  logic [ResWidth:0]     trial;
  logic                  fits;
  logic [ResWidth:0]     diff;

  assign neg_sum = {1'b0, ~dvd[DigitWidth-1:0]} + {{DigitWidth{1'b0}}, carry};
  assign trial   = {rem, dvd[CountWidth-1]};
  assign fits    = trial >= {1'b0, divisor};
  assign diff    = trial - {1'b0, divisor};

  always_comb begin
    phase_next = phase;
    unique case (phase)
      DV_IDLE: begin
        if (start) begin
          phase_next = dividend[CountWidth-1] ? DV_NEG : DV_RUN;
        end
      end
      DV_NEG: begin
        if (cnt[2:0] == 3'd7) begin
          phase_next = DV_RUN;
        end
      end
      DV_RUN: begin
        if (cnt == 6'd63) begin
          phase_next = DV_IDLE;
        end
      end
      default: phase_next = DV_IDLE;
    endcase
  end

  always_comb begin
    load_en = 1'b0;
    neg_en  = 1'b0;
    run_en  = 1'b0;
    unique case (phase)
      DV_IDLE: load_en = start;
      DV_NEG:  neg_en  = 1'b1;
      DV_RUN:  run_en  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= DV_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= run_en && (cnt == 6'd63);
      if (load_en || (neg_en && cnt[2:0] == 3'd7)) begin
        cnt <= '0;
      end else if (neg_en || run_en) begin
        cnt <= cnt + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      dvd   <= dividend;
      neg   <= dividend[CountWidth-1];
      rem   <= '0;
      carry <= 1'b1;
    end else if (neg_en) begin
      // Two's complement negation, one byte per cycle from the low end.
      dvd   <= {neg_sum[DigitWidth-1:0], dvd[CountWidth-1:DigitWidth]};
      carry <= neg_sum[DigitWidth];
    end else if (run_en) begin
      // Quotient bits enter at the bottom as dividend bits leave the top.
      dvd <= {dvd[CountWidth-2:0], fits};
      rem <= fits ? diff[ResWidth-1:0] : trial[ResWidth-1:0];
    end
  end

  assign result.done      = done;
  assign result.negative  = neg;
  assign result.quotient  = dvd;
  assign result.remainder = rem;

endmodule

// ===== rtl/encoder_turn_position_tracker.sv =====
// Top level of the encoder turn and position tracker.
// Each transfer on the input adds a signed 32-bit pulse delta to a wrapping
// 64-bit total and yields one result: the total, the whole turns (total over
// resolution, truncated toward zero, saturated to 32 bits) and the position
// within the turn (0 to resolution - 1). An item passes through a byte-serial
// add, then, when the new total is negative, a byte-serial step that takes its
// magnitude, and then the bit-serial divider. With a zero resolution the
// divider is skipped; with input disabled the add is skipped too, the total is
// cleared and the result is all zero. A new item is taken once the previous
// one has reached the output register, even while that result still waits to
// be read.
module encoder_turn_position_tracker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [etpt_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [etpt_pkg::CfgDataWidth-1:0]    cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [31:0]                          s_tdata,  // [31:0] count_delta
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [63:0] total_count, [95:64] turns, [127:96] position_in_turn
  output logic [127:0]                         m_tdata
);
  import etpt_pkg::*;

  logic [ResWidth-1:0]   resolution;
  logic                  input_enable;
  ctrl_state_t           state;
  ctrl_state_t           state_next;
  logic                  item_off;

  acc_ctrl_t             acc_ctrl;
  logic [CountWidth-1:0] total;
  logic                  acc_done;
  logic                  div_start;
  div_result_t           div_res;

  logic                  s_xfer;
  logic                  load_out;
  logic                  res_zero;
  logic                  quo_high;
  logic [DeltaWidth-1:0] turns_val;
  logic [ResWidth-1:0]   pos_val;

  logic [CountWidth-1:0] out_total;
  logic [DeltaWidth-1:0] out_turns;
  logic [ResWidth-1:0]   out_pos;

  assign s_xfer   = s_tvalid && s_tready;
  assign res_zero = (resolution == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution   <= RESOLUTION_RESET;
      input_enable <= INPUT_ENABLE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ENCODER_RESOLUTION) begin
        resolution <= cfg_data;
      end else if (cfg_index == REG_INPUT_ENABLE) begin
        input_enable <= cfg_data[0];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          state_next = input_enable ? ST_ACCUM : ST_FIN;
        end
      end
      ST_ACCUM: begin
        if (acc_done) begin
          state_next = res_zero ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    load_out  = (state == ST_FIN) && (!m_tvalid || m_tready);
    div_start = (state == ST_ACCUM) && acc_done && !res_zero;
    // Disabling input, by register or per item, drops the total to zero.
    acc_ctrl.start = s_xfer && input_enable;
    acc_ctrl.clear = (s_xfer && !input_enable)
                     || (cfg_we && cfg_index == REG_INPUT_ENABLE && !cfg_data[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      item_off <= !input_enable;
    end
  end

  etpt_accum u_accum (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (acc_ctrl),
    .delta (s_tdata),
    .total (total),
    .done  (acc_done)
  );

  etpt_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total),
    .divisor  (resolution),
    .result   (div_res)
  );

  // A negative quotient saturates once its magnitude passes 2^31, a nonnegative one once it passes 2^31 - 1.
  always_comb begin
    if (div_res.negative) begin
      quo_high  = (div_res.quotient[CountWidth-1:32] != '0)
                  || (div_res.quotient[31] && div_res.quotient[30:0] != '0);
      turns_val = quo_high ? TURNS_MIN : (~div_res.quotient[31:0] + 32'd1);
      pos_val   = (div_res.remainder != '0) ? (resolution - div_res.remainder)
                                            : '0;
    end else begin
      quo_high  = (div_res.quotient[CountWidth-1:31] != '0);
      turns_val = quo_high ? TURNS_MAX : div_res.quotient[31:0];
      pos_val   = div_res.remainder;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_total <= item_off ? '0 : total;
      out_turns <= (item_off || res_zero) ? '0 : turns_val;
      out_pos   <= (item_off || res_zero) ? '0 : pos_val;
    end
  end

  assign m_tdata = {out_pos, out_turns, out_total};

  a_fin_loads : assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("finished item did not reach the output register");

  a_acc_done_state : assert property (@(posedge clk) disable iff (rst)
    acc_done |-> (state == ST_ACCUM))
    else $error("accumulator finished outside the add phase");

  a_div_done_state : assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_valid_source : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FIN))
    else $error("output became valid without a finished item");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the encoder turn and position tracker.
`timescale 1ns / 1ps

module tb_top;
  import etpt_pkg::*;

  localparam logic [CfgIndexWidth-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned QUIET_LIMIT     = 6000;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned PHASE_ITEMS     = 135;
  localparam int unsigned DISABLED_ITEMS  = 30;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] turns;
    logic [63:0] total;
  } position_t;

  class position_predictor;
    logic [63:0] pulse_sum;
    logic [31:0] divisor;
    logic        counting;
    position_t   pending[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned saturations;
    int unsigned neg_multiples;
    int unsigned held_items;

    function new();
      pulse_sum = '0;
      divisor = RESOLUTION_RESET;
      counting = INPUT_ENABLE_RESET;
      mismatches = 0;
      checked = 0;
      saturations = 0;
      neg_multiples = 0;
      held_items = 0;
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      if (idx == REG_ENCODER_RESOLUTION) begin
        divisor = data;
      end else if (idx == REG_INPUT_ENABLE) begin
        counting = data[0];
        if (!counting) pulse_sum = '0;
      end
    endfunction

    // Works out the result for one accepted delta and queues it.
    function void take_delta(logic [31:0] delta);
      position_t p;
      logic [63:0] mag;
      logic [63:0] quo;
      logic [63:0] rem;
      logic below;
      p = '0;
      if (!counting) begin
        pulse_sum = '0;
        held_items++;
      end else begin
        pulse_sum = pulse_sum + {{32{delta[31]}}, delta};
        p.total = pulse_sum;
        if (divisor != 0) begin
          below = pulse_sum[63];
          mag = below ? -pulse_sum : pulse_sum;
          quo = mag / {32'b0, divisor};
          rem = mag % {32'b0, divisor};
          if (below) begin
            if (quo > 64'h8000_0000) begin
              p.turns = TURNS_MIN;
              saturations++;
            end else begin
              p.turns = -quo[31:0];
            end
            // A remainder of zero stays zero; the resolution is only added
            // to a true negative remainder.
            if (rem != 0) begin
              p.pos = divisor - rem[31:0];
            end else begin
              p.pos = '0;
              if (quo != 0) neg_multiples++;
            end
          end else begin
            if (quo > 64'h7FFF_FFFF) begin
              p.turns = TURNS_MAX;
              saturations++;
            end else begin
              p.turns = quo[31:0];
            end
            p.pos = rem[31:0];
          end
        end
      end
      pending.push_back(p);
    endfunction

    function void check_position(logic [127:0] word);
      position_t seen;
      position_t want;
      seen = word;
      if (pending.size() == 0) begin
        $error("result with no delta pending: total_count=%0d", $signed(seen.total));
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (seen.total !== want.total) begin
        $error("total_count: expected %0d, got %0d", $signed(want.total), $signed(seen.total));
        mismatches++;
      end
      if (seen.turns !== want.turns) begin
        $error("turns: expected %0d, got %0d", $signed(want.turns), $signed(seen.turns));
        mismatches++;
      end
      if (seen.pos !== want.pos) begin
        $error("position_in_turn: expected %0d, got %0d", want.pos, seen.pos);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [31:0]              s_tdata;   // [31:0] count_delta
  logic                     m_tvalid;
  logic                     m_tready;
  // [63:0] total_count, [95:64] turns, [127:96] position_in_turn
  logic [127:0]             m_tdata;

  position_predictor tracker = new();
  bit          receiver_hold;
  int unsigned deltas_sent;
  int unsigned settings_applied;
  int unsigned quiet_cycles;

  encoder_turn_position_tracker DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // Mostly small moves, some whole multiples of the resolution, some full-range
  // and extreme values, and steady drift that pushes the turn count outward.
  function automatic logic [31:0] pick_delta(logic [31:0] res, bit drift_up);
    int unsigned r;
    logic [31:0] mag;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    mag = $urandom_range(32'h7FFF_FFFF, 32'h1000_0000);
    k = $urandom_range(1, 3);
    if (r < 45) return $urandom_range(0, 4000) - 2000;
    if (r < 65) return $urandom_range(0, 1) ? res * k : -(res * k);
    if (r < 80) return $urandom;
    if (r < 88) begin
      case ($urandom_range(0, 4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        3: return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end
    return drift_up ? mag : -mag;
  endfunction

  task automatic send_delta(input logic [31:0] delta);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= delta;
    do @(posedge clk); while (!s_tready);
    tracker.take_delta(delta);
    deltas_sent++;
  endtask

  task automatic write_register(input logic [CfgIndexWidth-1:0] idx,
                                input logic [CfgDataWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_tracking(input logic [31:0] res, input logic enable);
    write_register(REG_ENCODER_RESOLUTION, res);
    write_register(REG_INPUT_ENABLE, {31'b0, enable});
    settings_applied++;
  endtask

  // Receiver: random stalls, stretches of steady readiness and a long hold-off
  // on request, and a check of every result transfer.
  initial begin
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned r;
    stall_left = 0;
    free_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_position(m_tdata);
      if (receiver_hold) begin
        receiver_hold = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
        free_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (free_left > 0) begin
        free_left--;
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          free_left = $urandom_range(50, 400);
          m_tready <= 1'b1;
        end else if (r < 60) begin
          m_tready <= 1'b1;
        end else if (r < 93) begin
          stall_left = $urandom_range(0, 3);
          m_tready <= 1'b0;
        end else begin
          stall_left = $urandom_range(20, 150);
          m_tready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] opening[11];
    logic [31:0] res;
    logic        enable;
    bit          drift_up;
    int unsigned n_items;
    opening = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h0000_0001, 32'hFFFE_0000, 32'hFFFD_FFFF, 32'h0004_0001,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    receiver_hold = 1'b0;
    deltas_sent = 0;
    settings_applied = 1;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: sign changes, an exact negative multiple of the
    // resolution and the extremes of the delta.
    foreach (opening[i]) send_delta(opening[i]);
    s_tvalid <= 1'b0;
    wait_results_drained();

    // A resolution of one drives the turn count past both saturation limits.
    set_tracking(32'd1, 1'b1);
    repeat (3) send_delta(32'h7FFF_FFFF);
    repeat (5) send_delta(32'h8000_0000);
    s_tvalid <= 1'b0;
    wait_results_drained();

    // Zero resolution, ignored register indexes, then disabled input.
    set_tracking(32'd0, 1'b1);
    send_delta(32'd5);
    s_tvalid <= 1'b0;
    wait_results_drained();
    write_register(REG_SPARE_A, $urandom);
    write_register(REG_SPARE_B, $urandom);
    write_register(REG_INPUT_ENABLE, 32'd0);
    send_delta(32'h1234_5678);
    s_tvalid <= 1'b0;
    wait_results_drained();
    set_tracking(32'hFFFF_FFFF, 1'b1);
    send_delta(32'hFFFF_FFFF);
    s_tvalid <= 1'b0;
    wait_results_drained();

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      enable = 1'b1;
      n_items = PHASE_ITEMS;
      case (phase)
        0: res = RESOLUTION_RESET;
        1: res = 32'd1;
        2: res = 32'hFFFF_FFFF;
        3: res = $urandom_range(2, 16);
        4: res = 32'd0;
        5: begin
          res = $urandom;
          enable = 1'b0;
          n_items = DISABLED_ITEMS;
        end
        6: res = 32'd1 << $urandom_range(0, 31);
        7: res = $urandom;
        8: res = $urandom_range(1000, 5000);
        default: res = 32'd3;
      endcase
      if (phase == 7) write_register(REG_SPARE_B, $urandom);
      set_tracking(res, enable);
      drift_up = $urandom_range(0, 1);
      for (int unsigned i = 0; i < n_items; i++) begin
        if (i == n_items / 2) drift_up = !drift_up;
        // The output is held off long enough for the block to fill up and
        // refuse further input while deltas are still offered.
        if ((phase == 1 || phase == 7) && i == 30) receiver_hold = 1'b1;
        if (phase == 3 && i == 60) begin
          s_tvalid <= 1'b0;
          wait_results_drained();
        end
        send_delta(pick_delta(res, drift_up));
      end
      s_tvalid <= 1'b0;
      wait_results_drained();
    end

    repeat (100) @(posedge clk);
    $display("Checked %0d results from %0d deltas over %0d register settings.",
             tracker.checked, deltas_sent, settings_applied);
    $display("Saturated turns: %0d, exact negative multiples: %0d, deltas while disabled: %0d.",
             tracker.saturations, tracker.neg_multiples, tracker.held_items);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
